### rtl/tccw_pkg.sv
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared sizes, codes and helpers for the text console character writer.
// ----------------------------------------------------------------------------
package tccw_pkg;

  localparam int SCREEN_WIDTH  = 80;
  localparam int SCREEN_HEIGHT = 25;
  localparam int CELL_COUNT    = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int ADDR_W        = $clog2(CELL_COUNT);

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int LOC_W  = 12;
  localparam int CELL_W = 16;
  localparam int NIB_W  = 4;

  localparam logic [ADDR_W-1:0] LAST_CELL      = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] LAST_ROW_BASE  = ADDR_W'((SCREEN_HEIGHT - 1) * SCREEN_WIDTH);
  localparam logic [ADDR_W-1:0] ROW_STRIDE     = ADDR_W'(SCREEN_WIDTH);

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_BLANK = 8'h20;
  localparam int         TAB_STOP = 8;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_GOTO  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic {
    REG_FG = 1'b0,
    REG_BG = 1'b1
  } reg_idx_t;

  // linear cell location: row * width + col
  function automatic logic [LOC_W-1:0] cell_loc(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
    return LOC_W'(int'(r) * SCREEN_WIDTH + int'(c));
  endfunction

endpackage

### rtl/text_console_char_writer_top.sv
// ----------------------------------------------------------------------------
// text_console_char_writer_top
// Text console engine: character-cell frame buffer in one synchronous RAM,
// cursor handling, scroll, clear and cell read-back.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------
//  in_     | sink      | in_tvalid / in_tready  | tuser: cmd; tdata: char,col,row
//  out_    | source    | out_tvalid / out_tready| tdata: cursor, location, cell
//  cfg_    | sink      | cfg_we (no wait)       | cfg_addr, cfg_wdata (nibbles)
//
// Sweeps: clear blanks every cell (one RAM write per cycle); a put that scrolls
//   copies rows up and blanks the last row (one RAM read and one write a cycle).
//   The single-write-port frame RAM sets the sweep lengths.
// Reset: a clearing pass writes blanks into all CELL_COUNT cells (2000 at 80x25)
//   of the RAM; in_tready stays low until it ends.
// Stalls: the result register holds one word; the next word is accepted while
//   it waits. A finished command waits in RESULT until the register is free.
// ----------------------------------------------------------------------------
module text_console_char_writer_top
  import tccw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // input stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [23:0]       in_tdata,   // [7:0] char_code, [15:8] col, [23:16] row
  input  logic [1:0]        in_tuser,   // [1:0] cmd
  // result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [39:0]       out_tdata,  // [6:0] cursor_col, [11:7] cursor_row,
                                        // [23:12] cursor_location, [39:24] cell_data
  // configuration
  input  logic              cfg_we,
  input  logic              cfg_addr,
  input  logic [NIB_W-1:0]  cfg_wdata
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_RDWAIT = 5'b00010,
    ST_SCROLL = 5'b00100,
    ST_FILL   = 5'b01000,
    ST_RESULT = 5'b10000
  } state_t;

  // unpack input word
  cmd_t       in_cmd;
  logic [7:0] in_char;
  logic [7:0] in_col;
  logic [7:0] in_row;

  assign in_cmd  = cmd_t'(in_tuser);
  assign in_char = in_tdata[7:0];
  assign in_col  = in_tdata[15:8];
  assign in_row  = in_tdata[23:16];

  // registers
  state_t              state_r, state_nxt;
  logic [COL_W-1:0]    cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0]    cur_row_r, cur_row_nxt;
  logic [NIB_W-1:0]    fg_r, bg_r;
  logic [ADDR_W-1:0]   cnt_r, cnt_nxt;          // sweep address
  logic [CELL_W-1:0]   fill_val_r, fill_val_nxt;
  logic                post_res_r, post_res_nxt; // result pending after a sweep
  logic                rd_ok_r, rd_ok_nxt;
  logic [CELL_W-1:0]   cell_r, cell_nxt;
  logic                pipe_v_r;                 // scroll copy in flight
  logic [ADDR_W-1:0]   pipe_addr_r;
  logic                out_valid_r;
  logic [39:0]         out_data_r;

  // frame RAM
  logic [CELL_W-1:0]   mem [CELL_COUNT];
  logic [CELL_W-1:0]   mem_rdata_r;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [CELL_W-1:0]   mem_wdata;
  logic [ADDR_W-1:0]   mem_raddr;

  logic                in_acc;
  logic [7:0]          attr;
  logic [COL_W:0]      pc_col;   // one extra bit for overrun
  logic [ROW_W:0]      pc_row;
  logic                pc_write;
  logic                in_col_ok, in_row_ok;
  logic [LOC_W-1:0]    rd_loc;
  logic [LOC_W-1:0]    cur_loc;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign attr      = {fg_r, bg_r};

  assign in_col_ok = in_col < 8'(SCREEN_WIDTH);
  assign in_row_ok = in_row < 8'(SCREEN_HEIGHT);
  assign rd_loc    = cell_loc(in_row[ROW_W-1:0], in_col[COL_W-1:0]);
  assign cur_loc   = cell_loc(cur_row_r, cur_col_r);

  // put-char cursor step with line wrap, before scroll
  always_comb begin
    pc_col   = {1'b0, cur_col_r};
    pc_row   = {1'b0, cur_row_r};
    pc_write = 1'b0;
    priority if (in_char == CH_BS) begin
      if (cur_col_r != '0) pc_col = pc_col - 1'b1;
    end else if (in_char == CH_TAB) begin
      pc_col = (pc_col + (COL_W+1)'(TAB_STOP)) & ~(COL_W+1)'(TAB_STOP - 1);
    end else if (in_char == CH_CR) begin
      pc_col = '0;
    end else if (in_char == CH_LF) begin
      pc_col = '0;
      pc_row = pc_row + 1'b1;
    end else if (in_char >= CH_BLANK) begin
      pc_write = 1'b1;
      pc_col   = pc_col + 1'b1;
    end else begin
      pc_col = {1'b0, cur_col_r};   // other control bytes do nothing
    end
    if (pc_col >= (COL_W+1)'(SCREEN_WIDTH)) begin
      pc_col = '0;
      pc_row = pc_row + 1'b1;
    end
  end

  // control
  always_comb begin
    state_nxt    = state_r;
    cur_col_nxt  = cur_col_r;
    cur_row_nxt  = cur_row_r;
    cnt_nxt      = cnt_r;
    fill_val_nxt = fill_val_r;
    post_res_nxt = post_res_r;
    rd_ok_nxt    = rd_ok_r;
    cell_nxt     = cell_r;
    mem_we       = 1'b0;
    mem_waddr    = cur_loc[ADDR_W-1:0];
    mem_wdata    = {attr, in_char};
    mem_raddr    = rd_loc[ADDR_W-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cell_nxt = '0;
          unique case (in_cmd)
            CMD_PUT: begin
              mem_we    = pc_write;
              cur_col_nxt = pc_col[COL_W-1:0];
              if (pc_row >= (ROW_W+1)'(SCREEN_HEIGHT)) begin
                // scroll: copy rows up, then blank the last row
                cur_row_nxt  = ROW_W'(SCREEN_HEIGHT - 1);
                cnt_nxt      = ROW_STRIDE;
                fill_val_nxt = {attr, CH_BLANK};
                post_res_nxt = 1'b1;
                state_nxt    = ST_SCROLL;
              end else begin
                cur_row_nxt = pc_row[ROW_W-1:0];
                state_nxt   = ST_RESULT;
              end
            end
            CMD_GOTO: begin
              if (in_col_ok) cur_col_nxt = in_col[COL_W-1:0];
              if (in_row_ok) cur_row_nxt = in_row[ROW_W-1:0];
              state_nxt = ST_RESULT;
            end
            CMD_CLEAR: begin
              cur_col_nxt  = '0;
              cur_row_nxt  = '0;
              cnt_nxt      = '0;
              fill_val_nxt = {in_char, CH_BLANK};
              post_res_nxt = 1'b1;
              state_nxt    = ST_FILL;
            end
            CMD_READ: begin
              rd_ok_nxt = in_col_ok && in_row_ok;
              state_nxt = ST_RDWAIT;
            end
            default: state_nxt = ST_RESULT;
          endcase
        end
      end
      ST_RDWAIT: begin
        cell_nxt  = rd_ok_r ? mem_rdata_r : '0;
        state_nxt = ST_RESULT;
      end
      ST_SCROLL: begin
        mem_raddr = cnt_r;
        mem_we    = pipe_v_r;
        mem_waddr = pipe_addr_r;
        mem_wdata = mem_rdata_r;
        if (cnt_r == LAST_CELL) begin
          cnt_nxt   = LAST_ROW_BASE;
          state_nxt = ST_FILL;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_FILL: begin
        if (pipe_v_r) begin
          // last scroll copy drains first
          mem_we    = 1'b1;
          mem_waddr = pipe_addr_r;
          mem_wdata = mem_rdata_r;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = cnt_r;
          mem_wdata = fill_val_r;
          if (cnt_r == LAST_CELL) begin
            state_nxt = post_res_r ? ST_RESULT : ST_IDLE;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      ST_RESULT: begin
        if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // frame RAM, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rdata_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;        // reset clearing pass
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      fg_r        <= '0;
      bg_r        <= '0;
      cnt_r       <= '0;
      fill_val_r  <= {8'h00, CH_BLANK};
      post_res_r  <= 1'b0;
      pipe_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cur_col_r  <= cur_col_nxt;
      cur_row_r  <= cur_row_nxt;
      cnt_r      <= cnt_nxt;
      fill_val_r <= fill_val_nxt;
      post_res_r <= post_res_nxt;
      pipe_v_r   <= (state_r == ST_SCROLL);
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_addr))
          REG_FG:  fg_r <= cfg_wdata;
          REG_BG:  bg_r <= cfg_wdata;
          default: fg_r <= fg_r;
        endcase
      end
      if (state_r == ST_RESULT && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_ok_r     <= rd_ok_nxt;
    cell_r      <= cell_nxt;
    pipe_addr_r <= cnt_r - ROW_STRIDE;
    if (state_r == ST_RESULT && (!out_valid_r || out_tready)) begin
      out_data_r <= {cell_r, cur_loc, cur_row_r, cur_col_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_cursor_in_screen: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(cur_col_r) < SCREEN_WIDTH) && (int'(cur_row_r) < SCREEN_HEIGHT))
    else $error("cursor outside screen");

  a_copy_from_scroll: assert property (@(posedge clk) disable iff (!rst_n)
    pipe_v_r |-> ($past(state_r) == ST_SCROLL))
    else $error("scroll copy without scroll read");

  a_scroll_to_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCROLL && cnt_r == LAST_CELL) |=> (state_r == ST_FILL && pipe_v_r))
    else $error("scroll did not hand over to last-row fill");

  a_sweep_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FILL && !pipe_v_r && cnt_r == LAST_CELL) |=> (state_r != ST_FILL))
    else $error("fill sweep overran");
`endif

endmodule
